@@ hdl/swr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package swr_pkg;

    // Bytes held by one 64-bit word register.
    localparam int REG_BYTES    = 8;
    localparam int IDX_W        = $clog2(REG_BYTES);
    // Counts run from 0 to REG_BYTES inclusive.
    localparam int CNT_W        = 4;
    localparam int CFG_IDX_W    = 8;
    localparam int CFG_DATA_W   = 64;

    // Defaults for the top-level parameters.
    localparam int MAX_WORD_DEF = 8;
    localparam int QUEUE_DEF    = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_SEARCH_LEN  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_SEARCH_WORD = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_REPLACE_LEN = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_REPLACE_WORD = CFG_IDX_W'(3);

    typedef logic [REG_BYTES-1:0][7:0] t_bytes;

    // One emit job handed from the front to the back: the first count
    // bytes are sent in order; fin marks the end of the string.
    typedef struct packed {
        t_bytes             bytes;
        logic [CNT_W-1:0]   count;
        logic               fin;
    } t_job;

endpackage

`default_nettype wire

@@ hdl/swr_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module swr_front
    import swr_pkg::*;
#(
    parameter int MAX_WORD = MAX_WORD_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    output logic                        o_ready,
    input  wire logic [7:0]             i_in_byte,
    input  wire logic                   i_in_final,
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data,
    output logic                        o_push,
    output t_job                        o_job,
    input  wire logic                   i_full
);

    localparam int CAP = (MAX_WORD < REG_BYTES) ? MAX_WORD : REG_BYTES;
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAP);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EVAL = 1'b1;

    logic                   r_state;
    logic [3:0]             r_slen_raw;
    logic [63:0]            r_sword;
    logic [3:0]             r_rlen_raw;
    logic [63:0]            r_rword;
    logic [7:0]             r_pend [CAP];
    logic [CNT_W-1:0]       r_count;
    logic                   r_fin;

    logic [7:0]             n_pend [CAP];
    logic [CNT_W-1:0]       n_count;
    logic [CNT_W-1:0]       slen;
    logic [CNT_W-1:0]       rlen;
    logic [CAP:0]           ok;
    logic [CNT_W-1:0]       sh;
    logic                   full_match;
    logic                   need_push;
    logic                   eval_go;
    logic                   accept;
    logic                   cfg_clear;
    t_job                   job;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = (r_state == ST_IDLE);
    assign accept      = i_valid && o_ready;

    // A new search length or search word drops the held bytes.
    assign cfg_clear   = i_cfg_valid && o_cfg_ready &&
                         ((i_cfg_index == REG_SEARCH_LEN) || (i_cfg_index == REG_SEARCH_WORD));

    // Effective lengths: search length at least one, both capped.
    always_comb begin
        slen = r_slen_raw;
        if (slen == '0) begin
            slen = CNT_W'(1);
        end
        if (slen > CAP_CNT) begin
            slen = CAP_CNT;
        end
        rlen = r_rlen_raw;
        if (rlen > CAP_CNT) begin
            rlen = CAP_CNT;
        end
    end

    // For each drop amount s, check that the pending bytes from s on still
    // form a prefix of the search word. Dropping everything always works.
    always_comb begin
        ok = '1;
        for (int s = 0; s < CAP; s++) begin
            for (int j = 0; j < CAP - s; j++) begin
                if ((CNT_W'(s + j) < r_count) && (r_pend[s + j] != r_sword[8*j +: 8])) begin
                    ok[s] = 1'b0;
                end
            end
        end
    end

    // Smallest drop amount that leaves a valid prefix.
    always_comb begin
        sh = CAP_CNT;
        for (int s = CAP; s >= 0; s--) begin
            if (ok[s]) begin
                sh = CNT_W'(s);
            end
        end
    end

    // Build the emit job: either the replacement or leading pending bytes.
    always_comb begin
        full_match = (r_count == slen) && ok[0];
        job.bytes  = '0;
        if (full_match) begin
            job.bytes = t_bytes'(r_rword);
        end else begin
            for (int i = 0; i < CAP; i++) begin
                job.bytes[i] = r_pend[i];
            end
        end
        if (full_match) begin
            job.count = rlen;
        end else if (r_fin) begin
            job.count = r_count;
        end else begin
            job.count = sh;
        end
        job.fin   = r_fin;
        need_push = r_fin || (job.count != '0);
        eval_go   = (r_state == ST_EVAL) && (!need_push || !i_full);
        o_push    = (r_state == ST_EVAL) && need_push && !i_full;
        o_job     = job;
    end

    // Pending bytes after the drop, and the new fill count.
    always_comb begin
        for (int i = 0; i < CAP; i++) begin
            n_pend[i] = r_pend[i];
        end
        for (int s = 1; s < CAP; s++) begin
            if (sh == CNT_W'(s)) begin
                for (int i = 0; i < CAP - s; i++) begin
                    n_pend[i] = r_pend[i + s];
                end
            end
        end
        if (full_match || r_fin) begin
            n_count = '0;
        end else begin
            n_count = r_count - sh;
        end
    end

    // Pending byte store: append on accept, realign after evaluation.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            for (int i = 0; i < CAP; i++) begin
                if (r_count == CNT_W'(i)) begin
                    r_pend[i] <= i_in_byte;
                end
            end
            r_fin <= i_in_final;
        end else if (eval_go) begin
            for (int i = 0; i < CAP; i++) begin
                r_pend[i] <= n_pend[i];
            end
        end
    end

    // Configuration registers, fill count and sequencing.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_slen_raw <= 4'd1;
            r_sword    <= '0;
            r_rlen_raw <= '0;
            r_rword    <= '0;
            r_count    <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_state <= ST_EVAL;
                    end
                end
                ST_EVAL: begin
                    if (eval_go) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
            // Fill count: cleared by a search reconfiguration, else tracks the data.
            if (cfg_clear) begin
                r_count <= '0;
            end else if (accept) begin
                r_count <= r_count + CNT_W'(1);
            end else if (eval_go) begin
                r_count <= n_count;
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_SEARCH_LEN: begin
                        r_slen_raw <= i_cfg_data[3:0];
                    end
                    REG_SEARCH_WORD: begin
                        r_sword <= i_cfg_data;
                    end
                    REG_REPLACE_LEN: begin
                        r_rlen_raw <= i_cfg_data[3:0];
                    end
                    REG_REPLACE_WORD: begin
                        r_rword <= i_cfg_data;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule

`default_nettype wire

@@ hdl/swr_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none

module swr_queue
    import swr_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_job   i_job,
    output logic        o_full,
    input  wire logic   i_pop,
    output t_job        o_job,
    output logic        o_avail
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int OCC_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [OCC_W-1:0] DEPTH_OCC = OCC_W'(DEPTH);

    t_job               r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr;
    logic [PTR_W-1:0]   r_rd;
    logic [OCC_W-1:0]   r_occ;
    logic               do_push;
    logic               do_pop;

    assign o_full  = (r_occ == DEPTH_OCC);
    assign o_avail = (r_occ != '0);
    assign o_job   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_avail;

    // Job storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    // Pointers and occupancy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_occ <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == LAST_PTR) ? '0 : r_wr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == LAST_PTR) ? '0 : r_rd + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_occ <= r_occ + OCC_W'(1);
            end else if (do_pop && !do_push) begin
                r_occ <= r_occ - OCC_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

@@ hdl/swr_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module swr_back
    import swr_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_job   i_job,
    input  wire logic   i_avail,
    output logic        o_pop,
    output logic        o_valid,
    input  wire logic   i_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_out_present,
    output logic        o_run_last,
    output logic        o_string_done
);

    logic               r_busy;
    t_job               r_job;
    logic [CNT_W-1:0]   r_idx;
    logic               r_valid;
    logic [7:0]         r_byte;
    logic               r_present;
    logic               r_last;
    logic               r_done;

    logic               slot_free;
    logic               emit;
    logic               bare;
    logic               last_word;

    assign slot_free = !r_valid || i_ready;
    assign emit      = r_busy && slot_free;
    assign o_pop     = !r_busy && i_avail;
    assign bare      = (r_job.count == '0);
    assign last_word = bare || (r_idx == r_job.count - CNT_W'(1));

    assign o_valid       = r_valid;
    assign o_out_byte    = r_byte;
    assign o_out_present = r_present;
    assign o_run_last    = r_last;
    assign o_string_done = r_done;

    // Current job and output word payload.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
        end
        if (emit) begin
            r_byte    <= bare ? 8'd0 : r_job.bytes[r_idx[IDX_W-1:0]];
            r_present <= !bare;
            r_last    <= last_word;
            r_done    <= last_word && r_job.fin;
        end
    end

    // Job sequencing and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (emit) begin
                if (last_word) begin
                    r_busy <= 1'b0;
                end
                r_idx <= r_idx + CNT_W'(1);
            end
            if (emit) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

@@ hdl/stream_word_replace_top.sv @@
// Streaming find-and-replace on a byte string. Each word accepted on the
// input channel is one text byte; the block replaces every non-overlapping
// occurrence of the search word (matched greedily, left to right) with the
// replacement word, which may be empty, and passes other bytes through in
// order. A byte marked final flushes the held bytes and the last result of
// the string carries string_done; a final byte with nothing to send gives a
// single end marker with out_present low. Every result that closes the work
// of one input byte carries run_last. The front takes each input byte in
// its idle state, then in its evaluate state compares the held bytes against
// the search word and queues any emit job, stalling while the queue is full;
// it takes no new byte meanwhile. The back sends one result per cycle while
// the output is not stalled, and pops each job from the queue only while it
// is idle, before its first result; a two-entry job queue absorbs bursts.
// Configuration writes are taken at any time but should only be made while
// the block is idle; writing the search length or search word discards
// held bytes.
`timescale 1ns / 1ps
`default_nettype none

module stream_word_replace_top
    import swr_pkg::*;
#(
    parameter int MAX_WORD    = MAX_WORD_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    output logic                        o_ready,
    input  wire logic [7:0]             i_in_byte,
    input  wire logic                   i_in_final,
    output logic                        o_valid,
    input  wire logic                   i_ready,
    output logic [7:0]                  o_out_byte,
    output logic                        o_out_present,
    output logic                        o_run_last,
    output logic                        o_string_done,
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data
);

    logic   push;
    t_job   push_job;
    logic   q_full;
    logic   pop;
    t_job   head_job;
    logic   q_avail;

    // Front: takes bytes, tracks the partial match and builds emit jobs.
    swr_front #(
        .MAX_WORD   (MAX_WORD)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_in_byte   (i_in_byte),
        .i_in_final  (i_in_final),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_push      (push),
        .o_job       (push_job),
        .i_full      (q_full)
    );

    // Job queue between front and back.
    swr_queue #(
        .DEPTH      (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_job      (push_job),
        .o_full     (q_full),
        .i_pop      (pop),
        .o_job      (head_job),
        .o_avail    (q_avail)
    );

    // Back: turns each job into output words.
    swr_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job         (head_job),
        .i_avail       (q_avail),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_out_byte    (o_out_byte),
        .o_out_present (o_out_present),
        .o_run_last    (o_run_last),
        .o_string_done (o_string_done)
    );

endmodule

`default_nettype wire

@@ hdl/swr_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module swr_checker
    import swr_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       o_valid,
    input  wire logic       i_ready,
    input  wire logic [7:0] o_out_byte,
    input  wire logic       o_out_present,
    input  wire logic       o_run_last,
    input  wire logic       o_string_done
);

    // A stalled output word stays valid.
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("output word dropped while stalled");

    // A stalled output word keeps its payload.
    a_payload_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(o_out_byte) && $stable(o_out_present)
            && $stable(o_run_last) && $stable(o_string_done))
        else $error("output payload changed while stalled");

    // An end marker closes both the byte's run and the string.
    a_bare_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_out_present |-> o_run_last && o_string_done)
        else $error("end marker without run_last and string_done");

    // The end of a string is also the end of a run.
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_string_done |-> o_run_last)
        else $error("string_done without run_last");

    // An end marker carries a zero byte.
    a_bare_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_out_present |-> o_out_byte == 8'd0)
        else $error("end marker with nonzero byte");

endmodule

bind stream_word_replace_top swr_checker u_swr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_out_byte    (o_out_byte),
    .o_out_present (o_out_present),
    .o_run_last    (o_run_last),
    .o_string_done (o_string_done)
);

`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import swr_pkg::*;

    localparam int WORD_CAP    = (MAX_WORD_DEF < REG_BYTES) ? MAX_WORD_DEF : REG_BYTES;
    localparam int SETTLE      = 20;
    localparam int LONG_HOLD   = 300;
    localparam int PHASES      = 9;
    localparam int PHASE_BYTES = 35;
    localparam int TIMEOUT_NS  = 5_000_000;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = REG_REPLACE_WORD + 1'b1;

    typedef struct packed {
        logic [7:0] data;
        logic       fin;
    } t_text_in;

    typedef struct packed {
        logic [7:0] data;
        logic       present;
        logic       run_last;
        logic       done;
    } t_text_out;

    // Clock, reset and the block's inputs, all known from time zero.
    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic [7:0]            in_byte   = '0;
    logic                  in_final  = 1'b0;
    logic                  out_ready = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    wire logic       in_ready;
    wire logic       out_valid;
    wire logic [7:0] out_byte;
    wire logic       out_present;
    wire logic       out_run_last;
    wire logic       out_done;
    wire logic       cfg_ready;

    // Text waiting to be sent, and replaced text still owed by the block.
    t_text_in  source_text_q[$];
    t_text_out replaced_text_q[$];
    t_text_in  next_char;
    int unsigned queued_n    = 0;
    int unsigned accepted_n  = 0;
    int unsigned mismatch_n  = 0;
    int unsigned out_word_n  = 0;

    // Idling controls for the sender and the receiver.
    bit          gaps_on         = 1'b1;
    int unsigned long_hold_asked = 0;
    int unsigned long_hold_seen  = 0;
    int unsigned send_gap        = 0;
    int unsigned stall_left      = 0;

    // Mirror of the block's registers and held bytes.
    logic [3:0]  srch_len  = 4'd1;
    logic [63:0] srch_word = '0;
    logic [3:0]  repl_len  = '0;
    logic [63:0] repl_word = '0;
    logic [7:0]  held [REG_BYTES];
    int unsigned held_n    = 0;

    // Search word and its length as seen by the text generator.
    logic [63:0] gen_word = '0;
    int unsigned gen_len  = 1;

    stream_word_replace_top uut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_valid       (in_valid),
        .o_ready       (in_ready),
        .i_in_byte     (in_byte),
        .i_in_final    (in_final),
        .o_valid       (out_valid),
        .i_ready       (out_ready),
        .o_out_byte    (out_byte),
        .o_out_present (out_present),
        .o_run_last    (out_run_last),
        .o_string_done (out_done),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // Length registers: zero search length acts as one, both saturate at the word size.
    function automatic int unsigned clamp_len(logic [3:0] v, bit floor_one);
        int unsigned n;
        n = v;
        if (floor_one && n < 1) n = 1;
        if (n > WORD_CAP) n = WORD_CAP;
        return n;
    endfunction

    function automatic t_text_out text_byte(logic [7:0] d, logic present);
        t_text_out w;
        w.data     = present ? d : 8'h00;
        w.present  = present;
        w.run_last = 1'b0;
        w.done     = 1'b0;
        return w;
    endfunction

    function automatic bit held_is_prefix();
        for (int i = 0; i < held_n; i++)
            if (held[i] != srch_word[8*i +: 8]) return 1'b0;
        return 1'b1;
    endfunction

    // Register writes; a new search length or word drops the held bytes.
    function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        case (idx)
            REG_SEARCH_LEN: begin
                srch_len = val[3:0];
                held_n   = 0;
            end
            REG_SEARCH_WORD: begin
                srch_word = val;
                held_n    = 0;
            end
            REG_REPLACE_LEN:  repl_len  = val[3:0];
            REG_REPLACE_WORD: repl_word = val;
            default: ;
        endcase
    endfunction

    // Works out the words one text byte releases and queues them.
    function automatic void replace_step(logic [7:0] b, logic fin);
        t_text_out   burst[$];
        int unsigned slen;
        slen = clamp_len(srch_len, 1'b1);
        if (held_n >= slen) held_n = 0;
        held[held_n] = b;
        held_n++;
        if (held_n == slen && held_is_prefix()) begin
            for (int i = 0; i < clamp_len(repl_len, 1'b0); i++)
                burst.push_back(text_byte(repl_word[8*i +: 8], 1'b1));
            held_n = 0;
        end else begin
            // Release leading bytes until the rest is a prefix again.
            while (held_n > 0 && !held_is_prefix()) begin
                burst.push_back(text_byte(held[0], 1'b1));
                for (int i = 1; i < held_n; i++) held[i-1] = held[i];
                held_n--;
            end
        end
        if (fin) begin
            for (int i = 0; i < held_n; i++) burst.push_back(text_byte(held[i], 1'b1));
            held_n = 0;
            if (burst.size() == 0) burst.push_back(text_byte(8'h00, 1'b0));
        end
        if (burst.size() > 0) begin
            burst[burst.size()-1].run_last = 1'b1;
            burst[burst.size()-1].done     = fin;
        end
        foreach (burst[i]) replaced_text_q.push_back(burst[i]);
    endfunction

    // Mostly no gap, some short ones, now and then a long one.
    function automatic int unsigned pick_gap();
        if (!gaps_on) return 0;
        case ($urandom_range(15))
            0:             return $urandom_range(30, 10);
            1, 2, 3, 4, 5: return $urandom_range(3, 1);
            default:       return 0;
        endcase
    endfunction

    // Sender: offers queued bytes, holding each until it is taken.
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            send_gap = 0;
        end else if (!in_valid || in_ready) begin
            if (send_gap > 0) begin
                send_gap--;
                in_valid <= 1'b0;
            end else if (source_text_q.size() > 0) begin
                next_char = source_text_q.pop_front();
                in_valid <= 1'b1;
                in_byte  <= next_char.data;
                in_final <= next_char.fin;
                send_gap = pick_gap();
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off on request.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
            stall_left = 0;
        end else if (long_hold_asked != long_hold_seen) begin
            long_hold_seen = long_hold_asked;
            stall_left     = LONG_HOLD;
            out_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            out_ready <= 1'b0;
        end else begin
            stall_left = pick_gap();
            out_ready <= (stall_left == 0);
        end
    end

    // Tracks accepted writes and bytes, and checks every word that comes out.
    always @(posedge clk) begin
        if (!rst_n) begin
            srch_len  = 4'd1;
            srch_word = '0;
            repl_len  = '0;
            repl_word = '0;
            held_n    = 0;
        end else begin
            if (cfg_valid && cfg_ready) apply_reg(cfg_index, cfg_data);
            if (in_valid && in_ready) begin
                replace_step(in_byte, in_final);
                accepted_n++;
            end
            if (out_valid && out_ready) begin
                out_word_n++;
                if (replaced_text_q.size() == 0) begin
                    mismatch_n++;
                    if (mismatch_n <= 10)
                        $display("tb: word %0d not expected: byte %h present %b last %b done %b",
                                 out_word_n, out_byte, out_present, out_run_last, out_done);
                end else begin
                    automatic t_text_out want = replaced_text_q.pop_front();
                    if (out_byte !== want.data || out_present !== want.present ||
                        out_run_last !== want.run_last || out_done !== want.done) begin
                        mismatch_n++;
                        if (mismatch_n <= 10)
                            $display({"tb: word %0d mismatch (expected/actual): byte %h/%h ",
                                      "present %b/%b last %b/%b done %b/%b"},
                                     out_word_n, want.data, out_byte, want.present,
                                     out_present, want.run_last, out_run_last,
                                     want.done, out_done);
                    end
                end
            end
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic queue_byte(logic [7:0] b, logic fin);
        t_text_in c;
        c.data = b;
        c.fin  = fin;
        source_text_q.push_back(c);
        queued_n++;
    endtask

    // Holds until every byte is taken and every word is back, then lets
    // the front finish any byte that releases nothing.
    task automatic wait_drained();
        do @(posedge clk); while (accepted_n != queued_n || replaced_text_q.size() != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Text rich in whole and partial copies of the search word.
    task automatic queue_string(int unsigned len, bit closes);
        logic [7:0]  chars[$];
        int unsigned m;
        int unsigned k;
        while (chars.size() < len) begin
            case ($urandom_range(9))
                0, 1, 2: chars.push_back(8'($urandom));
                3, 4, 5: begin
                    k = $urandom_range(gen_len - 1, 0);
                    chars.push_back(gen_word[8*k +: 8]);
                end
                default: begin
                    m = ($urandom_range(3) == 0) ? $urandom_range(gen_len, 1) : gen_len;
                    for (int i = 0; i < m; i++) chars.push_back(gen_word[8*i +: 8]);
                end
            endcase
        end
        foreach (chars[i]) queue_byte(chars[i], closes && i == chars.size() - 1);
    endtask

    // Random setting of all four registers, extremes favored.
    task automatic random_setup();
        logic [3:0]  s_len;
        logic [3:0]  r_len;
        logic [63:0] s_word;
        logic [63:0] r_word;
        logic [63:0] d;
        logic [7:0]  pa;
        logic [7:0]  pb;
        pa = 8'($urandom);
        pb = 8'($urandom);
        case ($urandom_range(7))
            0:       s_len = 4'd1;
            1:       s_len = 4'd8;
            2:       s_len = 4'd0;
            3:       s_len = 4'($urandom_range(15, 9));
            default: s_len = 4'($urandom_range(7, 2));
        endcase
        // Repeating and alternating words make prefixes overlap.
        case ($urandom_range(3))
            0:       s_word = {8{pa}};
            1:       s_word = {4{pb, pa}};
            2:       s_word = ({$urandom, $urandom} & {8{8'h03}}) | {8{8'h60}};
            default: s_word = {$urandom, $urandom};
        endcase
        case ($urandom_range(5))
            0:       r_len = 4'd0;
            1:       r_len = 4'd8;
            2:       r_len = 4'($urandom_range(15, 9));
            default: r_len = 4'($urandom_range(7, 1));
        endcase
        case ($urandom_range(5))
            0:       r_word = '0;
            1:       r_word = '1;
            default: r_word = {$urandom, $urandom};
        endcase
        d = {$urandom, $urandom};
        d[3:0] = s_len;
        write_reg(REG_SEARCH_LEN, d);
        write_reg(REG_SEARCH_WORD, s_word);
        d = {$urandom, $urandom};
        d[3:0] = r_len;
        write_reg(REG_REPLACE_LEN, d);
        write_reg(REG_REPLACE_WORD, r_word);
        if ($urandom_range(2) == 0)
            write_reg(CFG_IDX_W'($urandom_range(255, REG_UNUSED)), {$urandom, $urandom});
        gen_word = s_word;
        gen_len  = clamp_len(s_len, 1'b1);
    endtask

    // Stimulus: directed cases, random phases, then a back-pressure burst.
    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Reset setting deletes each zero byte; a lone final byte shows the end marker.
        queue_byte(8'h00, 1'b1);
        queue_byte(8'hFF, 1'b1);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'h5A, 1'b1);
        wait_drained();

        // Search "aab": a third 'a' breaks the prefix, then a match, then a flush.
        write_reg(REG_SEARCH_LEN, 64'd3);
        write_reg(REG_SEARCH_WORD, 64'h0000_0000_0062_6161);
        write_reg(REG_REPLACE_LEN, 64'd8);
        write_reg(REG_REPLACE_WORD, 64'h0123_4567_89AB_CDEF);
        queue_byte(8'h61, 1'b0);
        queue_byte(8'h61, 1'b0);
        queue_byte(8'h61, 1'b0);
        queue_byte(8'h62, 1'b0);
        queue_byte(8'h61, 1'b0);
        queue_byte(8'h61, 1'b1);
        queue_byte(8'h61, 1'b0);
        wait_drained();

        // New search word mid-string drops the held 'a'; an oversize length saturates.
        write_reg(REG_SEARCH_WORD, 64'h0);
        write_reg(REG_SEARCH_LEN, 64'd15);
        write_reg(REG_REPLACE_LEN, 64'd0);
        write_reg(REG_UNUSED, '1);
        for (int i = 0; i < 8; i++) queue_byte(8'h00, i == 7);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'h01, 1'b1);
        wait_drained();

        // Zero search length acts as one; replacement length saturates.
        write_reg(REG_SEARCH_LEN, 64'd0);
        write_reg(REG_SEARCH_WORD, '1);
        write_reg(REG_REPLACE_LEN, 64'd15);
        write_reg(REG_REPLACE_WORD, '1);
        queue_byte(8'hFF, 1'b1);
        wait_drained();

        // Random phases; some strings are left open across the next setting.
        for (int p = 0; p < PHASES; p++) begin
            gaps_on = (p != 2) && (p != 6);
            random_setup();
            while (queued_n < accepted_n + PHASE_BYTES)
                queue_string($urandom_range(12, 1), $urandom_range(4) != 0);
            wait_drained();
        end

        // Long receiver hold while the sender keeps offering bytes that expand.
        gaps_on = 1'b0;
        write_reg(REG_SEARCH_LEN, 64'd1);
        write_reg(REG_SEARCH_WORD, 64'h61);
        write_reg(REG_REPLACE_LEN, 64'd8);
        write_reg(REG_REPLACE_WORD, {$urandom, $urandom});
        gen_word = 64'h61;
        gen_len  = 1;
        long_hold_asked++;
        for (int i = 0; i < 30; i++)
            queue_byte(($urandom_range(4) == 0) ? 8'($urandom) : 8'h61, i == 29);
        gaps_on = 1'b1;
        wait_drained();

        mismatch_n += replaced_text_q.size();
        if (mismatch_n == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

    // Watchdog.
    initial begin
        #(TIMEOUT_NS);
        $display("tb: done, errors");
        $finish;
    end

endmodule
